// File: sv/mse_pkg.sv
`default_nettype none

package mse_pkg;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // One input beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] value_in;
        logic                     last_in;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     last_out;
        logic                     dropped;
    } t_out;

    // Status from the sequencer to the output stage.
    typedef struct packed {
        logic idle;
        logic push;
    } t_ctrl_status;

endpackage

`default_nettype wire

// File: sv/mse_mem.sv
`default_nettype none

// Simple dual-read, single-write synchronous RAM with registered read data.
module mse_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [mse_pkg::DATA_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr0,
    input  wire logic [AW-1:0]              i_raddr1,
    output logic      [mse_pkg::DATA_W-1:0] o_rdata0,
    output logic      [mse_pkg::DATA_W-1:0] o_rdata1
);

    logic [mse_pkg::DATA_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

// File: sv/mse_ctrl.sv
`default_nettype none

// Sequencer: loads values into bank A, runs bottom-up merge passes that
// ping-pong between banks A and B, then reads the sorted bank out.
module mse_ctrl #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire mse_pkg::t_in               i_in,
    input  wire logic                       i_out_free,
    output mse_pkg::t_ctrl_status           o_status,
    output mse_pkg::t_out                   o_out_data,
    output logic                            o_we_a,
    output logic                            o_we_b,
    output logic      [AW-1:0]              o_waddr,
    output logic      [mse_pkg::DATA_W-1:0] o_wdata,
    output logic                            o_re_a,
    output logic                            o_re_b,
    output logic      [AW-1:0]              o_raddr0,
    output logic      [AW-1:0]              o_raddr1,
    input  wire logic [mse_pkg::DATA_W-1:0] i_rdata0_a,
    input  wire logic [mse_pkg::DATA_W-1:0] i_rdata1_a,
    input  wire logic [mse_pkg::DATA_W-1:0] i_rdata0_b,
    input  wire logic [mse_pkg::DATA_W-1:0] i_rdata1_b
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MRD  = 3'd1;
    localparam logic [2:0] S_MCMP = 3'd2;
    localparam logic [2:0] S_RRD  = 3'd3;
    localparam logic [2:0] S_ROUT = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;
    logic [CW:0]   r_w, n_w;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_k, n_k;

    logic          full;
    logic [CW-1:0] cnt_inc;
    logic [CW:0]   w2;
    logic          seg_done;
    logic          pass_done;
    logic [CW-1:0] seg_lo, seg_n, seg_mid, seg_hi;
    logic [CW:0]   seg_w;
    logic [CW+1:0] seg_sum_mid, seg_sum_hi;
    logic [mse_pkg::DATA_W-1:0] left_v, right_v;
    logic          take_left;
    logic          read_last;

    // Element count after the current load beat.
    assign full    = (r_cnt == CW'(DEPTH));
    assign cnt_inc = full ? r_cnt : r_cnt + CW'(1);

    // Merge bookkeeping.
    assign w2        = r_w << 1;
    assign seg_done  = ((r_k + CW'(1)) == r_hi);
    assign pass_done = (r_hi == r_cnt);
    assign left_v    = r_src ? i_rdata0_b : i_rdata0_a;
    assign right_v   = r_src ? i_rdata1_b : i_rdata1_a;
    // Ties take the right-hand run.
    assign take_left = (r_i < r_mid) &&
                       ((r_j >= r_hi) || ($signed(left_v) < $signed(right_v)));
    assign read_last = ((r_k + CW'(1)) == r_cnt);

    // Start of the next pair of runs to merge.
    always_comb begin
        seg_lo = '0;
        seg_w  = r_w;
        seg_n  = r_cnt;
        case (r_state)
            S_IDLE: begin
                seg_w = (CW+1)'(1);
                seg_n = cnt_inc;
            end
            S_MCMP: begin
                if (pass_done) begin
                    seg_w = w2;
                end else begin
                    seg_lo = r_hi;
                end
            end
            default: begin
                seg_lo = '0;
            end
        endcase
    end

    // Run bounds, clipped to the element count.
    assign seg_sum_mid = {2'b00, seg_lo} + {1'b0, seg_w};
    assign seg_sum_hi  = seg_sum_mid + {1'b0, seg_w};
    assign seg_mid = (seg_sum_mid >= {2'b00, seg_n}) ? seg_n : seg_sum_mid[CW-1:0];
    assign seg_hi  = (seg_sum_hi >= {2'b00, seg_n}) ? seg_n : seg_sum_hi[CW-1:0];

    // Next state and memory commands.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_src    = r_src;
        n_w      = r_w;
        n_i      = r_i;
        n_j      = r_j;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_k      = r_k;
        o_we_a   = 1'b0;
        o_we_b   = 1'b0;
        o_waddr  = r_k[AW-1:0];
        o_wdata  = left_v;
        o_re_a   = 1'b0;
        o_re_b   = 1'b0;
        o_raddr0 = r_i[AW-1:0];
        o_raddr1 = r_j[AW-1:0];
        o_status.idle = (r_state == S_IDLE);
        o_status.push = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!full) begin
                        o_we_a  = 1'b1;
                        o_waddr = r_cnt[AW-1:0];
                        o_wdata = i_in.value_in;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cnt = cnt_inc;
                    if (i_in.last_in) begin
                        n_src = 1'b0;
                        n_k   = '0;
                        if (cnt_inc == CW'(1)) begin
                            n_state = S_RRD;
                        end else begin
                            n_w     = seg_w;
                            n_i     = seg_lo;
                            n_j     = seg_mid;
                            n_mid   = seg_mid;
                            n_hi    = seg_hi;
                            n_state = S_MRD;
                        end
                    end
                end
            end
            S_MRD: begin
                o_re_a  = !r_src;
                o_re_b  = r_src;
                n_state = S_MCMP;
            end
            S_MCMP: begin
                // Write the smaller head to the other bank.
                o_we_a  = r_src;
                o_we_b  = !r_src;
                o_wdata = take_left ? left_v : right_v;
                if (take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if (seg_done) begin
                    if (pass_done) begin
                        n_src = !r_src;
                    end
                    if (pass_done && (w2 >= {1'b0, r_cnt})) begin
                        n_k     = '0;
                        n_state = S_RRD;
                    end else begin
                        n_w     = seg_w;
                        n_i     = seg_lo;
                        n_k     = seg_lo;
                        n_j     = seg_mid;
                        n_mid   = seg_mid;
                        n_hi    = seg_hi;
                        n_state = S_MRD;
                    end
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_MRD;
                end
            end
            S_RRD: begin
                o_re_a   = !r_src;
                o_re_b   = r_src;
                o_raddr0 = r_k[AW-1:0];
                n_state  = S_ROUT;
            end
            S_ROUT: begin
                if (i_out_free) begin
                    o_status.push = 1'b1;
                    if (read_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result beat built from the sorted bank.
    always_comb begin
        o_out_data.value_out = left_v;
        o_out_data.last_out  = read_last;
        o_out_data.dropped   = r_ovf;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    // Merge pointers.
    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_w   <= n_w;
        r_i   <= n_i;
        r_j   <= n_j;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_k   <= n_k;
    end

endmodule

`default_nettype wire

// File: sv/merge_sort_engine.sv
`default_nettype none

// Merge sort engine. Signed 32-bit values are loaded one per beat into bank
// A of two DEPTH-entry RAMs; the beat with last_in set starts the sort, and
// no input is taken until the sorted values have all been handed to the
// output register. Values past DEPTH are discarded and dropped is then set
// on every result of that sequence. The sort runs ceil(log2(n)) bottom-up
// merge passes that ping-pong between the two banks; each merged element is
// read from the RAM, then compared and written, and each element of the
// readout is likewise read from the RAM, then pushed to the output register
// once it has room. Output stalls lengthen the readout. No clearing pass is
// needed after reset.
module merge_sort_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire mse_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output mse_pkg::t_out      o_out
);

    localparam int AW = $clog2(DEPTH);

    mse_pkg::t_ctrl_status      w_status;
    mse_pkg::t_out              w_out_data;
    logic                       w_out_free;
    logic                       w_we_a, w_we_b, w_re_a, w_re_b;
    logic [AW-1:0]              w_waddr, w_raddr0, w_raddr1;
    logic [mse_pkg::DATA_W-1:0] w_wdata;
    logic [mse_pkg::DATA_W-1:0] w_rdata0_a, w_rdata1_a, w_rdata0_b, w_rdata1_b;
    logic                       r_out_valid;
    mse_pkg::t_out              r_out;

    assign o_in_stall  = !w_status.idle;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer.
    mse_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_out_free (w_out_free),
        .o_status   (w_status),
        .o_out_data (w_out_data),
        .o_we_a     (w_we_a),
        .o_we_b     (w_we_b),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re_a     (w_re_a),
        .o_re_b     (w_re_b),
        .o_raddr0   (w_raddr0),
        .o_raddr1   (w_raddr1),
        .i_rdata0_a (w_rdata0_a),
        .i_rdata1_a (w_rdata1_a),
        .i_rdata0_b (w_rdata0_b),
        .i_rdata1_b (w_rdata1_b)
    );

    // Bank A holds loaded values; the banks swap roles every merge pass.
    mse_mem #(.DEPTH(DEPTH)) u_mem_a (
        .i_clk    (i_clk),
        .i_we     (w_we_a),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_re     (w_re_a),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0_a),
        .o_rdata1 (w_rdata1_a)
    );

    mse_mem #(.DEPTH(DEPTH)) u_mem_b (
        .i_clk    (i_clk),
        .i_we     (w_we_b),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_re     (w_re_b),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0_b),
        .o_rdata1 (w_rdata1_b)
    );

    // Output register: holds one result beat while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.push) begin
            r_out <= w_out_data;
        end
    end

    // The sequencer only pushes when the output register has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.push |-> w_out_free)
        else $error("result pushed into a full output register");

    // Pushing the final result returns the block to loading.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.push && w_out_data.last_out) |=> !o_in_stall)
        else $error("block not idle after the final result");

    // A beat marked last starts the sort and blocks further input.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in.last_in) |=> o_in_stall)
        else $error("input taken while sorting");

endmodule

`default_nettype wire

// File: verif/tb_merge_sort_engine.sv
`timescale 1ns / 100ps

module tb_merge_sort_engine;

    localparam int STORE_DEPTH  = 64;
    localparam int TARGET_ITEMS = 460;
    localparam int QUIET_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 300000;

    localparam logic signed [mse_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [mse_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    mse_pkg::t_in  in_beat   = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    mse_pkg::t_out out_beat;

    // Beats waiting to be sent, and sorted beats waiting to come back.
    mse_pkg::t_in  pending_beats[$];
    mse_pkg::t_out sorted_results[$];

    // Shadow of the element store as the sequence is loaded.
    logic signed [mse_pkg::DATA_W-1:0] held_values[STORE_DEPTH];
    int held_count    = 0;
    bit held_overflow = 1'b0;

    int error_count = 0;
    int cycle_count = 0;
    int gen_total   = 0;
    int send_gap    = 0;
    int stall_left  = 0;

    always #6 clk = ~clk;

    merge_sort_engine #(
        .DEPTH(STORE_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat)
    );

    // Near the end of the stimulus both sides run without idling.
    function automatic bit run_is_quiet();
        return pending_beats.size() < QUIET_ITEMS;
    endfunction

    // Store one accepted beat; on the last beat of a sequence, queue the
    // stored values in ascending signed order and start over empty.
    function automatic void predict_sorted(mse_pkg::t_in beat);
        logic signed [mse_pkg::DATA_W-1:0] ordered[STORE_DEPTH];
        logic signed [mse_pkg::DATA_W-1:0] key;
        mse_pkg::t_out res;
        int j;
        if (held_count < STORE_DEPTH) begin
            held_values[held_count] = beat.value_in;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (!beat.last_in) return;
        // Equal values are indistinguishable in the output, so any order
        // among them gives the same result stream.
        for (int i = 0; i < held_count; i++) begin
            key = held_values[i];
            j = i;
            while (j > 0 && ordered[j-1] > key) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        for (int i = 0; i < held_count; i++) begin
            res.value_out = ordered[i];
            res.last_out  = (i == held_count - 1);
            res.dropped   = held_overflow;
            sorted_results.push_back(res);
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    function automatic void add_item(logic signed [mse_pkg::DATA_W-1:0] value,
                                     logic last);
        mse_pkg::t_in beat;
        beat.value_in = value;
        beat.last_in  = last;
        pending_beats.push_back(beat);
        gen_total++;
    endfunction

    // Mix of full-range values, a narrow band that produces duplicates,
    // the extremes, and straight repeats of the previous value.
    function automatic logic signed [mse_pkg::DATA_W-1:0] pick_value(
        logic signed [mse_pkg::DATA_W-1:0] prev);
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom;
            3: return $signed($urandom_range(0, 15)) - 8;
            4: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    3: return -1;
                    default: return VAL_MIN + $urandom_range(0, 3);
                endcase
            end
            default: return prev;
        endcase
    endfunction

    function automatic void add_sequence(int len);
        logic signed [mse_pkg::DATA_W-1:0] prev;
        logic signed [mse_pkg::DATA_W-1:0] v;
        prev = 0;
        for (int i = 0; i < len; i++) begin
            v = pick_value(prev);
            add_item(v, i == len - 1);
            prev = v;
        end
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        int len;
        // Single element at the negative extreme.
        add_item(VAL_MIN, 1'b1);
        // Both extremes, given in descending order.
        add_item(VAL_MAX, 1'b0);
        add_item(VAL_MIN, 1'b1);
        // Sign boundary around zero with a repeated value.
        add_item(0, 1'b0);
        add_item(-1, 1'b0);
        add_item(1, 1'b0);
        add_item(VAL_MAX, 1'b0);
        add_item(VAL_MIN, 1'b0);
        add_item(-1, 1'b1);
        // Duplicates split across the merge halves.
        add_item(5, 1'b0);
        add_item(5, 1'b0);
        add_item(-5, 1'b0);
        add_item(5, 1'b1);

        // The store overflows on the last beat itself, then an exactly full
        // store, then an overflow by several beats.
        add_sequence(STORE_DEPTH + 1);
        add_sequence(STORE_DEPTH);
        add_sequence(STORE_DEPTH + 6);
        while (gen_total < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 4);
            else len = $urandom_range(1, 12);
            add_sequence(len);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_beats.size() == 0 && !in_valid && sorted_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("tb_merge_sort_engine: PASS");
        end else begin
            $display("tb_merge_sort_engine: FAIL");
        end
        $finish;
    end

    // Input driver: feeds pending beats, with random bursts of idle cycles.
    always @(posedge clk) begin
        bit taken;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken) predict_sorted(in_beat);
            if (!in_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!run_is_quiet() && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_beat  <= pending_beats.pop_front();
                end
            end
        end
    end

    // Output monitor: checks each accepted beat and stalls in random bursts.
    always @(posedge clk) begin
        mse_pkg::t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (sorted_results.size() == 0) begin
                    $error("unexpected result beat: value_out %0d", out_beat.value_out);
                    error_count++;
                end else begin
                    want = sorted_results.pop_front();
                    if (out_beat.value_out !== want.value_out) begin
                        $error("value_out: expected %0d, actual %0d",
                               want.value_out, out_beat.value_out);
                        error_count++;
                    end
                    if (out_beat.last_out !== want.last_out) begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last_out, out_beat.last_out);
                        error_count++;
                    end
                    if (out_beat.dropped !== want.dropped) begin
                        $error("dropped: expected %0b, actual %0b",
                               want.dropped, out_beat.dropped);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!run_is_quiet() && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_merge_sort_engine: FAIL");
            $finish;
        end
    end

endmodule
